### hw/rtl/rd_pkg.sv
// Shared types and widths for the restoring divider.
package rd_pkg;

  localparam int WIDTH  = 32;
  localparam int IN_W   = 2 * WIDTH;
  localparam int OUT_W  = 2 * WIDTH;

  // One pipeline slot: valid and divide-by-zero flags, partial remainder, shifting dividend/quotient, divisor.
  typedef struct packed {
    logic             valid;
    logic             dbz;
    logic [WIDTH-1:0] rem;
    logic [WIDTH-1:0] quo;
    logic [WIDTH-1:0] dvs;
  } rd_stage_t;

  typedef struct packed {
    logic             dbz;
    logic [WIDTH-1:0] remainder;
    logic [WIDTH-1:0] quotient;
  } rd_result_t;

endpackage

### hw/rtl/restoring_divider_top.sv
// Top level of the pipelined unsigned restoring divider.
// Input channel s_*: one word holds dividend and divisor; a word is taken
// when s_tvalid and s_tready are both high. Output channel m_*: quotient and
// remainder in m_tdata, divide-by-zero flag in m_tuser.
// The datapath is a row of 32 identical cells, one quotient bit per cell,
// each with its own register, so a new word can enter every cycle while
// s_tready is high. A word passes through the 32 cells and then the
// output register before it appears with m_tvalid.
// A zero divisor gives quotient and remainder of zero with m_tuser high.
// Reset (rst, synchronous) empties every cell and the output stage;
// s_tready goes high at the first clock edge with reset held.
// When the receiver stalls, the output word holds and one more word lands in
// a skid slot; s_tready then drops and the whole cell row freezes until the
// skid slot empties. s_tready comes straight from a register.
module restoring_divider_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [rd_pkg::IN_W-1:0]    s_tdata,   // dividend[31:0], divisor[63:32]
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [rd_pkg::OUT_W-1:0]   m_tdata,   // quotient[31:0], remainder[63:32]
  output logic                       m_tuser    // div_by_zero
);

  rd_pkg::rd_stage_t  stage [rd_pkg::WIDTH+1];
  rd_pkg::rd_result_t res;
  logic               en;
  logic               dbz_last;

  assign s_tready = en;

  always_comb begin
    stage[0].valid = s_tvalid;
    stage[0].dvs   = s_tdata[rd_pkg::IN_W-1:rd_pkg::WIDTH];
    stage[0].quo   = s_tdata[rd_pkg::WIDTH-1:0];
    stage[0].rem   = '0;
    stage[0].dbz   = (s_tdata[rd_pkg::IN_W-1:rd_pkg::WIDTH] == '0);
  end

  for (genvar i = 0; i < rd_pkg::WIDTH; i++) begin : g_cell
    rd_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .stage_in  (stage[i]),
      .stage_out (stage[i+1])
    );
  end

  always_comb begin
    dbz_last      = stage[rd_pkg::WIDTH].dbz;
    res.dbz       = dbz_last;
    res.quotient  = dbz_last ? '0 : stage[rd_pkg::WIDTH].quo;
    res.remainder = dbz_last ? '0 : stage[rd_pkg::WIDTH].rem;
  end

  rd_out_buf u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (en && stage[rd_pkg::WIDTH].valid),
    .res      (res),
    .ready    (en),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

### hw/rtl/rd_cell.sv
// One shift-subtract-restore step of the divider array, registered.
module rd_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  rd_pkg::rd_stage_t stage_in,
  output rd_pkg::rd_stage_t stage_out
);

  logic                   carry;
  logic [rd_pkg::WIDTH-1:0] shifted;
  logic [rd_pkg::WIDTH:0]   diff;
  logic                   take;
  rd_pkg::rd_stage_t      stage_next;

  always_comb begin
    carry   = stage_in.rem[rd_pkg::WIDTH-1];
    shifted = {stage_in.rem[rd_pkg::WIDTH-2:0], stage_in.quo[rd_pkg::WIDTH-1]};
    // extended partial remainder minus divisor; no borrow means it fits
    diff    = {carry, shifted} - {1'b0, stage_in.dvs};
    take    = ~diff[rd_pkg::WIDTH];
    stage_next       = stage_in;
    stage_next.rem   = take ? diff[rd_pkg::WIDTH-1:0] : shifted;
    stage_next.quo   = {stage_in.quo[rd_pkg::WIDTH-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_out.valid <= 1'b0;
    end else if (en) begin
      stage_out.valid <= stage_next.valid;
    end
    if (en) begin
      stage_out.dbz <= stage_next.dbz;
      stage_out.rem <= stage_next.rem;
      stage_out.quo <= stage_next.quo;
      stage_out.dvs <= stage_next.dvs;
    end
  end

  // restoring keeps the partial remainder below a nonzero divisor
  a_rem_below_dvs: assert property (@(posedge clk) disable iff (rst)
    (stage_out.valid && !stage_out.dbz) |-> (stage_out.rem < stage_out.dvs))
    else $error("partial remainder not below divisor");

endmodule

### hw/rtl/rd_out_buf.sv
// Output register with skid slot; its ready is a register.
module rd_out_buf (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  rd_pkg::rd_result_t         res,
  output logic                       ready,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [rd_pkg::OUT_W-1:0]   m_tdata,
  output logic                       m_tuser
);

  logic               skid_valid;
  rd_pkg::rd_result_t skid;
  rd_pkg::rd_result_t hold;

  assign ready    = ~skid_valid;
  assign m_tdata  = {hold.remainder, hold.quotient};
  assign m_tuser  = hold.dbz;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        hold       <= skid;
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        hold     <= res;
        m_tvalid <= push;
      end
    end else if (push) begin
      skid       <= res;
      skid_valid <= 1'b1;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid slot full while output empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && m_tready) |=> (m_tvalid && !skid_valid))
    else $error("skid word not moved to output");

  a_dbz_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("divide by zero word carries nonzero data");

endmodule
